// ===== rtl/core/swlb_pkg.sv =====
// Shared types and constants for the 5x5 sliding-window line buffer.
// Used by the line store, the window column cells, the top level and the checker.
package swlb_pkg;

  localparam int PIXEL_BITS     = 8;
  localparam int WIN_SIZE       = 5;
  localparam int STORE_LINES    = WIN_SIZE - 1;
  localparam int LAST_INDEX     = WIN_SIZE - 1;
  localparam int MAX_LINE_WIDTH = 128;
  localparam int COL_BITS       = $clog2(MAX_LINE_WIDTH);
  localparam int ROW_POS_BITS   = $clog2(LAST_INDEX + 1);
  localparam int WIDTH_BITS     = 8;
  localparam int ROW_BITS       = WIN_SIZE * PIXEL_BITS;

  localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RESET = WIDTH_BITS'(80);
  localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_MAX   = WIDTH_BITS'(MAX_LINE_WIDTH);

  typedef logic [PIXEL_BITS-1:0]                   pixel_t;
  // element 0 is the line just above
  typedef logic [STORE_LINES-1:0][PIXEL_BITS-1:0]  store_word_t;
  // one window column, element 0 is row a, element LAST_INDEX the current line
  typedef logic [WIN_SIZE-1:0][PIXEL_BITS-1:0]     column_t;
  typedef logic [COL_BITS-1:0]                     col_t;
  typedef logic [ROW_POS_BITS-1:0]                 row_pos_t;
  typedef logic [WIDTH_BITS-1:0]                   width_t;

  typedef struct packed {
    logic        rd_en;
    col_t        rd_addr;
    logic        wr_en;
    col_t        wr_addr;
    store_word_t wr_data;
  } store_req_t;

endpackage

// ===== rtl/core/swlb_line_store.sv =====
// Line store: one packed word of the four previous lines per column.
// Registered read with write-to-read bypass; per-entry valid bits make
// unwritten entries read as zero. Depends on swlb_pkg.
module swlb_line_store
  import swlb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  store_req_t  req,
  output store_word_t rd_data
);

  store_word_t                   mem [MAX_LINE_WIDTH];
  logic [MAX_LINE_WIDTH-1:0]     entry_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (req.wr_en) begin
      entry_vld[req.wr_addr] <= 1'b1;
    end
  end

  // a read of the column being written in the same cycle takes the new word
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
        rd_data <= req.wr_data;
      end else if (entry_vld[req.rd_addr]) begin
        rd_data <= mem[req.rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// ===== rtl/core/swlb_col_cell.sv =====
// One window column cell: holds five pixels, loads from its right neighbor on shift.
// Depends on swlb_pkg.
module swlb_col_cell
  import swlb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    shift,
  input  column_t d_in,
  output column_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d_in;
    end
  end

endmodule

// ===== rtl/core/sliding_window_line_buffer_core.sv =====
// Top level of the 5x5 sliding-window line buffer.
// Instantiates swlb_line_store and a chain of swlb_col_cell; uses swlb_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one raster-order pixel per
//   transaction. Output channel out_valid/out_ready carries the 5x5 window
//   after that pixel is shifted in, as five packed 40-bit rows (oldest column
//   in the low bits) plus window_valid, set once four full lines and four
//   columns of the current line have been seen.
//   line_width_we/line_width_data set the line width (reset 80); write it only
//   while no transaction is in flight.
//   The read stage registers an accepted pixel; the cells and out_valid load
//   when it fires. Throughput: one pixel per cycle unless the output stalls,
//   set by the simple dual-port line store read on accept, written back on fire.
//   Reset clears the window, column and row positions and the line store
//   valid bits, so stored lines read as zero, and sets the line width to 80;
//   there is no clearing pass and the block accepts pixels in the first cycle
//   after reset.
//   When the receiver stalls, the window is held on the outputs, one more
//   pixel is taken into the read stage, and then in_ready drops until the
//   output transaction completes.
module sliding_window_line_buffer_core
  import swlb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                line_width_we,
  input  logic [WIDTH_BITS-1:0] line_width_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PIXEL_BITS-1:0] pixel,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ROW_BITS-1:0] window_row_a,
  output logic [ROW_BITS-1:0] window_row_b,
  output logic [ROW_BITS-1:0] window_row_c,
  output logic [ROW_BITS-1:0] window_row_d,
  output logic [ROW_BITS-1:0] window_row_e,
  output logic                window_valid
);

  width_t      line_width;
  col_t        col;
  col_t        col_next;
  row_pos_t    row_pos;
  row_pos_t    row_pos_next;
  width_t      limit;
  width_t      col_inc;
  logic        accept;
  logic        s1_valid;
  logic        s1_fire;
  pixel_t      s1_pixel;
  col_t        s1_col;
  logic        s1_win_ok;
  logic        win_ok;
  store_req_t  store_req;
  store_word_t rd_data;
  column_t     new_col;
  column_t     cell_q [WIN_SIZE];

  assign accept   = in_valid && in_ready;
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
    end else if (line_width_we) begin
      line_width <= line_width_data;
    end
  end

  // column wraps at the line width, clamped to the store depth
  always_comb begin
    limit        = (line_width > LINE_WIDTH_MAX) ? LINE_WIDTH_MAX : line_width;
    col_inc      = WIDTH_BITS'(col) + WIDTH_BITS'(1);
    win_ok       = (row_pos >= ROW_POS_BITS'(LAST_INDEX)) && (col >= COL_BITS'(LAST_INDEX));
    col_next     = col_inc[COL_BITS-1:0];
    row_pos_next = row_pos;
    if (col_inc >= limit) begin
      col_next = '0;
      if (row_pos < ROW_POS_BITS'(LAST_INDEX)) begin
        row_pos_next = row_pos + ROW_POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row_pos <= '0;
    end else if (accept) begin
      col     <= col_next;
      row_pos <= row_pos_next;
    end
  end

  // read stage: waits for the line store data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel  <= pixel;
      s1_col    <= col;
      s1_win_ok <= win_ok;
    end
  end

  always_comb begin
    store_req.rd_en   = accept;
    store_req.rd_addr = col;
    store_req.wr_en   = s1_fire;
    store_req.wr_addr = s1_col;
    store_req.wr_data = {rd_data[STORE_LINES-2:0], s1_pixel};
  end

  swlb_line_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .rd_data (rd_data)
  );

  assign new_col = {s1_pixel, rd_data};

  // window: cell 0 holds the oldest column, the last cell the newest
  for (genvar i = 0; i < WIN_SIZE; i++) begin : g_cell
    if (i == WIN_SIZE - 1) begin : g_tail
      swlb_col_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (s1_fire),
        .d_in  (new_col),
        .q     (cell_q[i])
      );
    end else begin : g_body
      swlb_col_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (s1_fire),
        .d_in  (cell_q[i+1]),
        .q     (cell_q[i])
      );
    end
  end

  // the cells hold still while a result waits, so they drive the outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      window_valid <= s1_win_ok;
    end
  end

  always_comb begin
    for (int i = 0; i < WIN_SIZE; i++) begin
      window_row_a[i*PIXEL_BITS +: PIXEL_BITS] = cell_q[i][0];
      window_row_b[i*PIXEL_BITS +: PIXEL_BITS] = cell_q[i][1];
      window_row_c[i*PIXEL_BITS +: PIXEL_BITS] = cell_q[i][2];
      window_row_d[i*PIXEL_BITS +: PIXEL_BITS] = cell_q[i][3];
      window_row_e[i*PIXEL_BITS +: PIXEL_BITS] = cell_q[i][4];
    end
  end

endmodule

// ===== rtl/core/swlb_checker.sv =====
// Port-level checks for the sliding-window line buffer top level.
// Bound to sliding_window_line_buffer_core; depends on swlb_pkg.
module swlb_checker
  import swlb_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  line_width_we,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [PIXEL_BITS-1:0] pixel,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [ROW_BITS-1:0]   window_row_a,
  input logic [ROW_BITS-1:0]   window_row_b,
  input logic [ROW_BITS-1:0]   window_row_c,
  input logic [ROW_BITS-1:0]   window_row_d,
  input logic [ROW_BITS-1:0]   window_row_e,
  input logic                  window_valid
);

  // a stalled result keeps its window
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_row_a) && $stable(window_row_b)
      && $stable(window_row_c) && $stable(window_row_d) && $stable(window_row_e)
      && $stable(window_valid))
    else $error("stalled output window changed");

  // a fresh result follows an earlier input transaction
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching input transaction");

  // only one transaction can queue behind a stalled output
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && in_valid && in_ready ##1 out_valid && !out_ready |-> !in_ready)
    else $error("input accepted with read stage full and output stalled");

  // a waiting input keeps its pixel
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(pixel))
    else $error("waiting input transaction changed");

  // line width is written only with no result pending
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    line_width_we |-> !out_valid)
    else $error("line width written with a result pending");

endmodule

bind sliding_window_line_buffer_core swlb_checker u_swlb_checker (.*);

// ===== tb/sliding_window_line_buffer_core_tb.sv =====
// Self-checking testbench for sliding_window_line_buffer_core: a directed pixel table,
// then random raster streams over several line widths with random idling on both sides.
// Depends on swlb_pkg and the RTL under rtl/core.
module sliding_window_line_buffer_core_tb;
  import swlb_pkg::*;

  localparam int PERIOD       = 10;
  localparam int RUN_LIMIT    = 4_000_000;
  localparam int DIR_COUNT    = 25;
  localparam int PHASES       = 9;
  localparam int HOLD_CYCLES  = 60;
  localparam int HOLD_PHASE   = 2;
  localparam int HOLD_AT      = 100;
  localparam int PAUSE_PHASE  = 6;
  localparam int PAUSE_AT     = 125;
  localparam int SHOWN_ERRORS = 40;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] row_a;
    logic [ROW_BITS-1:0] row_b;
    logic [ROW_BITS-1:0] row_c;
    logic [ROW_BITS-1:0] row_d;
    logic [ROW_BITS-1:0] row_e;
    logic                valid;
  } window_t;

  // fixed rows: just after reset the stores are empty, so only row e is nonzero
  typedef struct packed {
    pixel_t              px;
    logic                fixed;
    logic [ROW_BITS-1:0] row_e;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_COUNT] = '{
    '{8'hFF, 1'b1, 40'hFF_0000_0000},
    '{8'h00, 1'b1, 40'h00_FF00_0000},
    '{8'h80, 1'b1, 40'h80_00FF_0000},
    '{8'h01, 1'b1, 40'h01_8000_FF00},
    '{8'h55, 1'b1, 40'h55_0180_00FF},
    '{8'hAA, 1'b0, 40'h0}, '{8'h7F, 1'b0, 40'h0}, '{8'hFE, 1'b0, 40'h0},
    '{8'h01, 1'b0, 40'h0}, '{8'h80, 1'b0, 40'h0}, '{8'h00, 1'b0, 40'h0},
    '{8'hFF, 1'b0, 40'h0}, '{8'h33, 1'b0, 40'h0}, '{8'hCC, 1'b0, 40'h0},
    '{8'h0F, 1'b0, 40'h0}, '{8'hF0, 1'b0, 40'h0}, '{8'h12, 1'b0, 40'h0},
    '{8'h34, 1'b0, 40'h0}, '{8'h56, 1'b0, 40'h0}, '{8'h78, 1'b0, 40'h0},
    '{8'h9A, 1'b0, 40'h0}, '{8'hBC, 1'b0, 40'h0}, '{8'hDE, 1'b0, 40'h0},
    '{8'hFF, 1'b0, 40'h0}, '{8'h00, 1'b0, 40'h0}
  };

  // 200 and 255 exceed the store depth; 0, 1 and 3 can never give a full window
  localparam int PHASE_WIDTH [PHASES] = '{128, 7, 200, 3, 0, 1, 80, 255, 5};
  localparam int PHASE_ITEMS [PHASES] = '{300, 150, 300, 60, 30, 30, 250, 150, 130};
  localparam idle_mode_t PHASE_MODE [PHASES] = '{
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE,
    IDLE_SENDER, IDLE_BOTH, IDLE_RECEIVER, IDLE_NONE
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                line_width_we = 1'b0;
  width_t              line_width_data = LINE_WIDTH_RESET;
  logic                in_valid = 1'b0;
  logic                in_ready;
  pixel_t              pixel = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ROW_BITS-1:0] window_row_a, window_row_b, window_row_c, window_row_d, window_row_e;
  logic                window_valid;

  // window model state
  logic [STORE_LINES*PIXEL_BITS-1:0] store_mem [MAX_LINE_WIDTH];
  logic [ROW_BITS-1:0]               win_rows [WIN_SIZE];
  int                                cur_col;
  int                                cur_row;
  width_t                            width_reg;

  window_t pending_windows [$];
  window_t exp_win;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_req = 0;
  int      hold_left = 0;
  int      error_count = 0;
  int      pixels_sent = 0;
  int      windows_checked = 0;
  int      full_windows = 0;
  int      widths_set = 0;

  sliding_window_line_buffer_core DUT (
    .clk             (clk),
    .rst             (rst),
    .line_width_we   (line_width_we),
    .line_width_data (line_width_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .pixel           (pixel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .window_row_a    (window_row_a),
    .window_row_b    (window_row_b),
    .window_row_c    (window_row_c),
    .window_row_d    (window_row_d),
    .window_row_e    (window_row_e),
    .window_valid    (window_valid)
  );

  always #(PERIOD / 2) clk = ~clk;

  function automatic window_t shift_in_pixel(input pixel_t px);
    logic [STORE_LINES*PIXEL_BITS-1:0] stored;
    pixel_t                            column [WIN_SIZE];
    int                                col;
    int                                limit;
    int                                r;
    window_t                           res;
    col = (cur_col >= MAX_LINE_WIDTH) ? 0 : cur_col;
    stored = store_mem[col];
    for (r = 0; r < STORE_LINES; r++)
      column[r] = stored[r*PIXEL_BITS +: PIXEL_BITS];
    column[LAST_INDEX] = px;
    // push the column down one line; the new pixel becomes the line just above
    store_mem[col] = {stored[(STORE_LINES-1)*PIXEL_BITS-1:0], px};
    for (r = 0; r < WIN_SIZE; r++)
      win_rows[r] = {column[r], win_rows[r][ROW_BITS-1:PIXEL_BITS]};
    res.valid = (cur_row >= LAST_INDEX) && (col >= LAST_INDEX);
    limit = (int'(width_reg) > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : int'(width_reg);
    if (col + 1 >= limit) begin
      cur_col = 0;
      if (cur_row < LAST_INDEX)
        cur_row++;
    end else begin
      cur_col = col + 1;
    end
    res.row_a = win_rows[0];
    res.row_b = win_rows[1];
    res.row_c = win_rows[2];
    res.row_d = win_rows[3];
    res.row_e = win_rows[4];
    return res;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < SHOWN_ERRORS)
      $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [ROW_BITS-1:0] got,
                             input logic [ROW_BITS-1:0] want);
    if (got !== want)
      flag_error($sformatf("%s: got %h, expected %h (window %0d)",
                           name, got, want, windows_checked));
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 67;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 67;
      end
      default: begin
        send_idle_pct = 31;
        recv_stall_pct = 31;
      end
    endcase
  endtask

  task automatic write_line_width(input width_t w);
    line_width_we <= 1'b1;
    line_width_data <= w;
    @(posedge clk);
    line_width_we <= 1'b0;
    width_reg = w;
    widths_set++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_windows.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_pixel(input pixel_t px, input logic fixed,
                            input logic [ROW_BITS-1:0] fixed_e);
    window_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (!in_ready);
    want = shift_in_pixel(px);
    if (fixed) begin
      want = '0;
      want.row_e = fixed_e;
    end
    pending_windows.push_back(want);
    pixels_sent++;
  endtask

  // receiver: checks each output transaction, then picks next cycle's ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_windows.size() == 0) begin
          flag_error("window transaction with nothing expected");
        end else begin
          exp_win = pending_windows.pop_front();
          check_field("window_row_a", window_row_a, exp_win.row_a);
          check_field("window_row_b", window_row_b, exp_win.row_b);
          check_field("window_row_c", window_row_c, exp_win.row_c);
          check_field("window_row_d", window_row_d, exp_win.row_d);
          check_field("window_row_e", window_row_e, exp_win.row_e);
          check_field("window_valid", ROW_BITS'(window_valid), ROW_BITS'(exp_win.valid));
          if (exp_win.valid)
            full_windows++;
          windows_checked++;
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    pixel_t px;
    int     k;
    int     p;
    int     n;
    for (k = 0; k < MAX_LINE_WIDTH; k++)
      store_mem[k] = '0;
    for (k = 0; k < WIN_SIZE; k++)
      win_rows[k] = '0;
    cur_col = 0;
    cur_row = 0;
    width_reg = LINE_WIDTH_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // narrow lines so the directed part reaches full windows
    write_line_width(width_t'(5));
    set_idle(IDLE_NONE);
    for (k = 0; k < DIR_COUNT; k++)
      send_pixel(DIR_TABLE[k].px, DIR_TABLE[k].fixed, DIR_TABLE[k].row_e);

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      // width changes land mid-line, so the column may already be past the new width
      write_line_width(width_t'(PHASE_WIDTH[p]));
      set_idle(PHASE_MODE[p]);
      for (n = 0; n < PHASE_ITEMS[p]; n++) begin
        if (p == HOLD_PHASE && n == HOLD_AT)
          hold_req = HOLD_CYCLES;
        if (p == PAUSE_PHASE && n == PAUSE_AT)
          wait_drained();
        case ($urandom_range(0, 7))
          0:       px = '0;
          1:       px = '1;
          default: px = pixel_t'($urandom_range(0, 255));
        endcase
        send_pixel(px, 1'b0, '0);
      end
    end

    wait_drained();
    $display("Streamed %0d pixels across %0d line width settings; %0d windows checked,",
             pixels_sent, widths_set, windows_checked);
    $display("%0d of them full 5x5 neighborhoods.", full_windows);
    if (error_count == 0) begin
      $display("sliding_window_line_buffer_core_tb passed");
    end else begin
      $display("sliding_window_line_buffer_core_tb failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Timeout with %0d windows still pending.", pending_windows.size());
    $display("sliding_window_line_buffer_core_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/swlb_pkg.sv
rtl/core/swlb_line_store.sv
rtl/core/swlb_col_cell.sv
rtl/core/sliding_window_line_buffer_core.sv
rtl/core/swlb_checker.sv
tb/sliding_window_line_buffer_core_tb.sv
